>>> rtl/core/mhpt_pkg.sv
// package for the masked header pattern trigger: codes, widths and shared types
package mhpt_pkg;

  // widths fixed by the register map and item fields
  localparam int unsigned LenW      = 5;
  localparam int unsigned TicksW    = 24;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned NumBytes  = 16;
  localparam int unsigned ByteIdxW  = 4;

  // defaults
  localparam int unsigned MaxMatchBytesDefault = 16;
  localparam logic [TicksW-1:0] TimeoutReset = 24'd3000000;
  localparam logic [TicksW-1:0] TicksMax     = 24'hFFFFFF;

  // input operation codes
  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_BYTE   = 2'd1,
    OP_DONE   = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  // result outcome codes
  typedef enum logic [1:0] {
    OUT_MATCHED  = 2'd0,
    OUT_MISMATCH = 2'd1,
    OUT_SHORT    = 2'd2,
    OUT_TIMEOUT  = 2'd3
  } outcome_e;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MATCH_LENGTH  = 3'd0,
    CFG_MASK_LOW      = 3'd1,
    CFG_MASK_HIGH     = 3'd2,
    CFG_PATTERN_LOW   = 3'd3,
    CFG_PATTERN_HIGH  = 3'd4,
    CFG_ACTION        = 3'd5,
    CFG_TIMEOUT       = 3'd6
  } cfg_idx_e;

  // configuration seen by the match logic
  typedef struct packed {
    logic [LenW-1:0]              match_length;
    logic [NumBytes-1:0][7:0]     mask;
    logic [NumBytes-1:0][7:0]     pattern;
    logic [1:0]                   action;
    logic [TicksW-1:0]            timeout;
  } cfg_t;

  // one result item
  typedef struct packed {
    logic [1:0] outcome;
    logic       fire;
    logic [1:0] action_code;
  } res_t;

  // match state status for checking
  typedef struct packed {
    logic            active;
    logic [LenW-1:0] pos;
  } status_t;

endpackage

>>> rtl/core/mhpt_ifs.sv
// channel interfaces: input items, result items and configuration writes
interface mhpt_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] rx_byte;

  modport source (output valid, output op, output rx_byte, input ready);
  modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

interface mhpt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] outcome;
  logic       fire;
  logic [1:0] action_code;

  modport source (output valid, output outcome, output fire, output action_code, input ready);
  modport sink   (input valid, input outcome, input fire, input action_code, output ready);
endinterface

interface mhpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/mhpt_cfg_regs.sv
// configuration register file for the pattern trigger
module mhpt_cfg_regs import mhpt_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [CfgIdxW-1:0]  wr_idx_i,
  input  logic [CfgDataW-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.match_length <= '0;
      cfg_q.mask         <= '0;
      cfg_q.pattern      <= '0;
      cfg_q.action       <= '0;
      cfg_q.timeout      <= TimeoutReset;
    end else if (wr_en_i) begin
      case (cfg_idx_e'(wr_idx_i))
        CFG_MATCH_LENGTH: cfg_q.match_length <= wr_data_i[LenW-1:0];
        CFG_MASK_LOW:     cfg_q.mask[7:0]     <= wr_data_i;
        CFG_MASK_HIGH:    cfg_q.mask[15:8]    <= wr_data_i;
        CFG_PATTERN_LOW:  cfg_q.pattern[7:0]  <= wr_data_i;
        CFG_PATTERN_HIGH: cfg_q.pattern[15:8] <= wr_data_i;
        CFG_ACTION:       cfg_q.action       <= wr_data_i[1:0];
        CFG_TIMEOUT:      cfg_q.timeout      <= wr_data_i[TicksW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> rtl/core/mhpt_match_core.sv
// match state and the per-item decision logic
module mhpt_match_core import mhpt_pkg::*; #(
  parameter int unsigned MaxMatchBytes = MaxMatchBytesDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] op_i,
  input  logic [7:0] rx_byte_i,
  input  cfg_t       cfg_i,
  output logic       res_valid_o,
  output res_t       res_o,
  output status_t    status_o
);

  localparam logic [LenW-1:0] MaxLen = LenW'(MaxMatchBytes);

  logic              active_q, active_d;
  logic [LenW-1:0]   pos_q, pos_d;
  logic [TicksW-1:0] elapsed_q, elapsed_d;

  logic [LenW-1:0]   len;
  logic [7:0]        mask_byte, pat_byte;
  logic [LenW-1:0]   pos_next;
  logic              mism;
  logic [TicksW-1:0] elapsed_inc;

  // effective length, clamped to the supported maximum
  assign len = (cfg_i.match_length > MaxLen) ? MaxLen : cfg_i.match_length;

  // mask and pattern byte at the current position
  assign mask_byte = cfg_i.mask[pos_q[ByteIdxW-1:0]];
  assign pat_byte  = cfg_i.pattern[pos_q[ByteIdxW-1:0]];

  // byte compare and tick count
  always_comb begin
    mism     = 1'b0;
    pos_next = pos_q;
    if (pos_q < len) begin
      if ((rx_byte_i & mask_byte) != pat_byte) begin
        mism = 1'b1;
      end else begin
        pos_next = pos_q + LenW'(1);
      end
    end
    elapsed_inc = (elapsed_q < TicksMax) ? elapsed_q + TicksW'(1) : elapsed_q;
  end

  // next state and result for the item in flight
  always_comb begin
    active_d    = active_q;
    pos_d       = pos_q;
    elapsed_d   = elapsed_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    if (step_i) begin
      if (op_e'(op_i) == OP_HEADER) begin
        active_d  = 1'b0;
        pos_d     = '0;
        elapsed_d = '0;
        if (len == '0) begin
          res_valid_o       = 1'b1;
          res_o.outcome     = OUT_MATCHED;
          res_o.fire        = 1'b1;
          res_o.action_code = cfg_i.action;
        end else begin
          active_d = 1'b1;
        end
      end else if (active_q) begin
        case (op_e'(op_i))
          OP_BYTE: begin
            if (mism) begin
              active_d      = 1'b0;
              pos_d         = '0;
              elapsed_d     = '0;
              res_valid_o   = 1'b1;
              res_o.outcome = OUT_MISMATCH;
            end else if (pos_next >= len) begin
              active_d          = 1'b0;
              pos_d             = '0;
              elapsed_d         = '0;
              res_valid_o       = 1'b1;
              res_o.outcome     = OUT_MATCHED;
              res_o.fire        = 1'b1;
              res_o.action_code = cfg_i.action;
            end else begin
              pos_d = pos_next;
            end
          end
          OP_DONE: begin
            active_d      = 1'b0;
            pos_d         = '0;
            elapsed_d     = '0;
            res_valid_o   = 1'b1;
            res_o.outcome = OUT_SHORT;
          end
          OP_TICK: begin
            if (elapsed_inc > cfg_i.timeout) begin
              active_d      = 1'b0;
              pos_d         = '0;
              elapsed_d     = '0;
              res_valid_o   = 1'b1;
              res_o.outcome = OUT_TIMEOUT;
            end else begin
              elapsed_d = elapsed_inc;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // match state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= 1'b0;
      pos_q     <= '0;
      elapsed_q <= '0;
    end else begin
      active_q  <= active_d;
      pos_q     <= pos_d;
      elapsed_q <= elapsed_d;
    end
  end

  assign status_o.active = active_q;
  assign status_o.pos    = pos_q;

endmodule

>>> rtl/core/masked_header_pattern_trigger_unit.sv
// top level of the masked header pattern trigger
// The unit takes one item per clock cycle while the input register is not stalled. An accepted
// item lands in an input register and is decided, once the input register advances, against the
// match state by a single masked byte compare or tick compare; a result, if the item causes one,
// is loaded into the result register as the item leaves the input register. The input register only
// stalls while a result waits in the result register and the sink does not take it.
// Configuration writes are taken in every cycle and apply from the next one.
module masked_header_pattern_trigger_unit import mhpt_pkg::*; #(
  parameter int unsigned MaxMatchBytes = MaxMatchBytesDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mhpt_in_if.sink      in_chan_i,
  mhpt_out_if.source   out_chan_o,
  mhpt_cfg_if.sink     cfg_chan_i
);

  cfg_t       cfg;
  logic       in_valid_q;
  logic [1:0] in_op_q;
  logic [7:0] in_byte_q;
  logic       advance;
  logic       res_valid;
  res_t       res;
  logic       out_valid_q;
  res_t       out_q;
  status_t    status;

  // configuration port
  assign cfg_chan_i.ready = 1'b1;

  mhpt_cfg_regs u_cfg_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_chan_i.valid),
    .wr_idx_i  (cfg_chan_i.index),
    .wr_data_i (cfg_chan_i.data),
    .cfg_o     (cfg)
  );

  // input register moves on when the result register has room
  assign advance         = in_valid_q && (!out_valid_q || out_chan_o.ready);
  assign in_chan_i.ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_chan_i.ready) begin
      in_valid_q <= in_chan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_chan_i.ready && in_chan_i.valid) begin
      in_op_q   <= in_chan_i.op;
      in_byte_q <= in_chan_i.rx_byte;
    end
  end

  mhpt_match_core #(
    .MaxMatchBytes (MaxMatchBytes)
  ) u_match_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .op_i        (in_op_q),
    .rx_byte_i   (in_byte_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res),
    .status_o    (status)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_chan_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_chan_o.valid       = out_valid_q;
  assign out_chan_o.outcome     = out_q.outcome;
  assign out_chan_o.fire        = out_q.fire;
  assign out_chan_o.action_code = out_q.action_code;

  // checks
  a_fire_only_on_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.fire) |-> (out_q.outcome == OUT_MATCHED))
    else $error("fire raised on an outcome other than matched");

  a_code_zero_without_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.fire) |-> (out_q.action_code == 2'd0))
    else $error("action code set without fire");

  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && res_valid) |=> (!status.active && status.pos == '0))
    else $error("match state not cleared after a result");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.pos <= LenW'(MaxMatchBytes))
    else $error("byte position beyond maximum match length");

  a_no_result_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_chan_o.ready) |-> !advance)
    else $error("pending result overwritten");

endmodule
